// File: hdl/icbd_pkg.sv
// Package for the integer code bit decoder.
// Holds the mode codes, register indexes, widths and the shared struct types.
// No dependencies; the design files refer to it by scoped names, the testbench imports it.
package icbd_pkg;

  localparam int unsigned OUT_W      = 32;  // width of a decoded word
  localparam int unsigned CNT_W      = 6;   // prefix counter and bits-left counter
  localparam int unsigned BETA_W     = 6;
  localparam int unsigned K_W        = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [BETA_W-1:0] BETA_MAX = BETA_W'(32);

  typedef enum logic [1:0] {
    MODE_BETA   = 2'd0,
    MODE_SUBEXP = 2'd1,
    MODE_GAMMA  = 2'd2,
    MODE_HOLD   = 2'd3   // bits are consumed, state is kept, nothing comes out
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECODE_MODE  = 2'd0,
    REG_VALUE_OFFSET = 2'd1,
    REG_BETA_WIDTH   = 2'd2,
    REG_SUBEXP_K     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    mode_e              mode;
    logic [OUT_W-1:0]   offset;
    logic [BETA_W-1:0]  beta_width;
    logic [K_W-1:0]     subexp_k;
  } cfg_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] decoded_value;
    logic                    prefix_error;
  } result_t;

endpackage

// File: hdl/icbd_if.sv
// Handshake interfaces of the integer code bit decoder: code bits in, decoded
// words out, and the configuration write channel. Depends on icbd_pkg.

interface icbd_in_if;
  logic valid;
  logic ready;
  logic code_bit;

  modport source (output valid, output code_bit, input ready);
  modport sink   (input valid, input code_bit, output ready);
endinterface

interface icbd_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [icbd_pkg::OUT_W-1:0]       decoded_value;
  logic                                    prefix_error;

  modport source (output valid, output decoded_value, output prefix_error, input ready);
  modport sink   (input valid, input decoded_value, input prefix_error, output ready);
endinterface

interface icbd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [icbd_pkg::CFG_IDX_W-1:0]    index;
  logic [icbd_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: hdl/integer_code_bit_decoder_top.sv
// Top level of the integer code bit decoder: input register, decoder core,
// configuration registers and result register. Depends on icbd_pkg, icbd_if,
// icbd_cfg_regs and icbd_core.
//
//   Port   | Kind    | Word carried
//   -------+---------+-------------------------------------------------
//   in_i   | sink    | code_bit, one bit of the coded stream, MSB first
//   out_o  | source  | decoded_value (signed 32) and prefix_error
//   cfg_i  | sink    | index and wdata of one register write
//
// The block takes one code bit per cycle unless in_i stalls. A bit is held
// in the input register, then updates the decoder state; a finished word
// is written into the result register when the bit that ends it leaves the
// input register, and is valid on out_o from there on.
// The result register decouples the two sides: bits keep flowing while a
// word waits, and in_i stalls only when a held bit would finish another word
// while the previous one is still untaken. Reset clears the decoder to the
// prefix phase in beta mode with beta_width 8, subexp_k 0 and offset 0.
// Writing decode_mode restarts the decoder; other registers take effect when
// next used. cfg_i is always ready.
module integer_code_bit_decoder_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  icbd_in_if.sink     in_i,
  icbd_out_if.source  out_o,
  icbd_cfg_if.sink    cfg_i
);

  icbd_pkg::cfg_t    cfg;
  logic              restart;
  logic              produce;
  icbd_pkg::result_t result;
  logic              core_idle;

  // Input register: one code bit waiting for the core.
  logic bit_valid_q;
  logic bit_q;

  // Result register.
  logic              out_valid_q;
  icbd_pkg::result_t out_data_q;

  logic out_free;
  logic advance;
  logic in_fire;

  icbd_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  icbd_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (restart),
    .step_i    (advance),
    .bit_i     (bit_q),
    .produce_o (produce),
    .result_o  (result),
    .idle_o    (core_idle)
  );

  // The held bit moves on unless it finishes a word and the result
  // register still holds one that the sink has not taken.
  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = bit_valid_q && (!produce || out_free);
  assign in_i.ready = !bit_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_valid_q <= 1'b0;
    end else if (in_fire) begin
      bit_valid_q <= 1'b1;
    end else if (advance) begin
      bit_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bit_q <= in_i.code_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && produce) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.decoded_value = out_data_q.decoded_value;
  assign out_o.prefix_error  = out_data_q.prefix_error;

  // An error word always carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.prefix_error |-> out_o.decoded_value == '0)
    else $error("prefix error word with nonzero value");

  // The input side stalls only behind a full, untaken result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> bit_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled without a blocked result");

  // A mode write leaves the decoder in its starting state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.ready && cfg_i.index == icbd_pkg::REG_DECODE_MODE
    |=> core_idle)
    else $error("decoder not restarted after a mode write");

  // In hold mode no new word enters the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.mode == icbd_pkg::MODE_HOLD |-> !(advance && produce))
    else $error("word produced in hold mode");

endmodule

// File: hdl/icbd_cfg_regs.sv
// Configuration registers of the integer code bit decoder.
// Depends on icbd_pkg and icbd_if; flags a restart when the mode is written.
module icbd_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  icbd_cfg_if.sink          cfg_i,
  output icbd_pkg::cfg_t    cfg_o,
  output logic              restart_o
);

  icbd_pkg::cfg_t cfg_q, cfg_d;
  logic           wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid && cfg_i.ready;

  always_comb begin
    cfg_d     = cfg_q;
    restart_o = 1'b0;
    if (wr) begin
      case (icbd_pkg::reg_idx_e'(cfg_i.index))
        icbd_pkg::REG_DECODE_MODE: begin
          cfg_d.mode = icbd_pkg::mode_e'(cfg_i.wdata[1:0]);
          restart_o  = 1'b1;
        end
        icbd_pkg::REG_VALUE_OFFSET: cfg_d.offset     = cfg_i.wdata[icbd_pkg::OUT_W-1:0];
        icbd_pkg::REG_BETA_WIDTH:   cfg_d.beta_width = cfg_i.wdata[icbd_pkg::BETA_W-1:0];
        icbd_pkg::REG_SUBEXP_K:     cfg_d.subexp_k   = cfg_i.wdata[icbd_pkg::K_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= icbd_pkg::MODE_BETA;
      cfg_q.offset     <= '0;
      cfg_q.beta_width <= icbd_pkg::BETA_W'(8);
      cfg_q.subexp_k   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/icbd_core.sv
// Decoder state for the integer code bit decoder, updated one bit per cycle
// while step_i is high. Depends on icbd_pkg. At most one result per consumed bit.
module icbd_core #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  icbd_pkg::cfg_t       cfg_i,
  input  logic                 restart_i,
  input  logic                 step_i,
  input  logic                 bit_i,
  output logic                 produce_o,
  output icbd_pkg::result_t    result_o,
  output logic                 idle_o
);

  localparam int unsigned CW = icbd_pkg::CNT_W;

  logic                   phase_q, phase_d;
  logic [CW-1:0]          prefix_q, prefix_d;
  logic [CW-1:0]          bits_q, bits_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;

  logic [CW-1:0]          prefix_inc;
  logic [CW-1:0]          beta_w;
  logic [CW-1:0]          suffix_cnt;
  logic                   preload;
  logic [CW-1:0]          bl;
  logic [VALUE_WIDTH-1:0] acc_base;
  logic [VALUE_WIDTH-1:0] acc_shift;
  logic [VALUE_WIDTH-1:0] emit_val;
  logic [icbd_pkg::OUT_W-1:0] emit_32;
  logic                   emit_err;

  // Beta width clamped into 1..32.
  always_comb begin
    if (cfg_i.beta_width == '0)                     beta_w = CW'(1);
    else if (cfg_i.beta_width > icbd_pkg::BETA_MAX) beta_w = CW'(32);
    else                                            beta_w = cfg_i.beta_width;
  end

  assign prefix_inc = prefix_q + CW'(1);
  assign acc_base   = phase_q ? acc_q : '0;
  assign bl         = phase_q ? bits_q : beta_w;
  assign acc_shift  = {acc_base[VALUE_WIDTH-2:0], bit_i};

  // Length of the suffix and the implicit leading bit once a prefix ends.
  always_comb begin
    if (cfg_i.mode == icbd_pkg::MODE_SUBEXP) begin
      if (prefix_q == '0) begin
        preload    = 1'b0;
        suffix_cnt = CW'(cfg_i.subexp_k);
      end else begin
        preload    = 1'b1;
        suffix_cnt = prefix_q + CW'(cfg_i.subexp_k) - CW'(1);
      end
    end else begin
      preload    = 1'b1;
      suffix_cnt = prefix_q;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    prefix_d  = prefix_q;
    bits_d    = bits_q;
    acc_d     = acc_q;
    produce_o = 1'b0;
    emit_err  = 1'b0;
    emit_val  = '0;
    if (cfg_i.mode == icbd_pkg::MODE_HOLD) begin
      produce_o = 1'b0;
    end else if (!phase_q && cfg_i.mode != icbd_pkg::MODE_BETA) begin
      if (bit_i == (cfg_i.mode == icbd_pkg::MODE_SUBEXP)) begin
        // Another prefix symbol; a prefix of 32 is an error.
        if (prefix_inc[CW-1]) begin
          produce_o = 1'b1;
          emit_err  = 1'b1;
        end else begin
          prefix_d = prefix_inc;
        end
      end else if (suffix_cnt == '0) begin
        produce_o = 1'b1;
        emit_val  = VALUE_WIDTH'(preload);
      end else begin
        phase_d = 1'b1;
        bits_d  = suffix_cnt;
        acc_d   = VALUE_WIDTH'(preload);
      end
    end else begin
      // Suffix bit; in beta mode the first bit also starts the word.
      if (bl <= CW'(1)) begin
        produce_o = 1'b1;
        emit_val  = acc_shift;
      end else begin
        phase_d = 1'b1;
        bits_d  = bl - CW'(1);
        acc_d   = acc_shift;
      end
    end
    if (produce_o) begin
      phase_d  = 1'b0;
      prefix_d = '0;
      bits_d   = '0;
      acc_d    = '0;
    end
  end

  generate
    if (VALUE_WIDTH >= icbd_pkg::OUT_W) begin : g_trunc
      assign emit_32 = emit_val[icbd_pkg::OUT_W-1:0];
    end else begin : g_ext
      assign emit_32 = {{(icbd_pkg::OUT_W-VALUE_WIDTH){1'b0}}, emit_val};
    end
  endgenerate

  assign result_o.decoded_value = emit_err ? '0 : $signed(emit_32 - cfg_i.offset);
  assign result_o.prefix_error  = emit_err;
  assign idle_o                 = !phase_q && (prefix_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 1'b0;
      prefix_q <= '0;
      bits_q   <= '0;
      acc_q    <= '0;
    end else if (restart_i) begin
      phase_q  <= 1'b0;
      prefix_q <= '0;
      bits_q   <= '0;
      acc_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      prefix_q <= prefix_d;
      bits_q   <= bits_d;
      acc_q    <= acc_d;
    end
  end

endmodule

// File: tb/integer_code_bit_decoder_top_test.sv
// Self-checking testbench for integer_code_bit_decoder_top: beta, subexponential
// and Elias gamma decoding, checked word by word against a built-in predictor.
// Depends on icbd_pkg, the icbd interfaces and the decoder RTL.
module integer_code_bit_decoder_top_test;
  import icbd_pkg::*;

  // The watchdog limit sits far above the slowest legal run, even with heavy
  // idling on both sides.
  localparam int unsigned MAX_CYCLES   = 200000;
  localparam int unsigned RANDOM_BITS  = 1450;
  localparam int unsigned RANDOM_WORDS = 48;
  // A bit sits in the input register and its word then in the result register;
  // SETTLE_CYCLES covers that with margin.
  localparam int unsigned SETTLE_CYCLES = 4;

  logic clk = 1'b0;
  logic rst_n;

  icbd_in_if  in_if ();
  icbd_out_if out_if ();
  icbd_cfg_if cfg_if ();

  integer_code_bit_decoder_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Percent chances, per cycle, that the bit source idles and that the word
  // sink stalls. Changed between test phases.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // Mirror of the configuration registers.
  mode_e            cfg_mode;
  logic [OUT_W-1:0] cfg_offset;
  logic [5:0]       cfg_beta;
  logic [4:0]       cfg_k;

  // Mirror of the decoder state.
  logic             in_suffix;
  logic [5:0]       prefix_len;
  logic [5:0]       suffix_left;
  logic [OUT_W-1:0] acc;

  // Words the decoder owes us, oldest first.
  result_t expected_words[$];

  int unsigned bits_decoded    = 0;
  int unsigned words_predicted = 0;
  int unsigned words_checked   = 0;
  int unsigned errors_checked  = 0;
  int unsigned writes_done     = 0;
  int unsigned mismatches      = 0;
  int unsigned cycle_count;
  result_t     want;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void restart_decoder();
    in_suffix   = 1'b0;
    prefix_len  = '0;
    suffix_left = '0;
    acc         = '0;
  endfunction

  function automatic void reset_model();
    cfg_mode   = MODE_BETA;
    cfg_offset = '0;
    cfg_beta   = 6'd8;
    cfg_k      = '0;
    restart_decoder();
  endfunction

  // A finished word leaves minus the offset; an overflowed prefix leaves zero.
  function automatic void finish_word(logic [OUT_W-1:0] value, logic err);
    result_t r;
    r.decoded_value = err ? '0 : value - cfg_offset;
    r.prefix_error  = err;
    expected_words.push_back(r);
    words_predicted++;
    restart_decoder();
  endfunction

  function automatic void enter_suffix(logic [OUT_W-1:0] preload, logic [5:0] count);
    if (count == 0) begin
      finish_word(preload, 1'b0);
    end else begin
      acc         = preload;
      suffix_left = count;
      in_suffix   = 1'b1;
    end
  endfunction

  function automatic void decode_bit(logic b);
    logic [5:0] w;
    logic       prefix_sym;
    if (cfg_mode == MODE_HOLD) return;
    if (!in_suffix) begin
      if (cfg_mode == MODE_BETA) begin
        // A zero width counts as one, anything above 32 as 32. This bit is
        // already the first bit of the value.
        w           = (cfg_beta == 0) ? 6'd1 : ((cfg_beta > 32) ? 6'd32 : cfg_beta);
        acc         = '0;
        suffix_left = w;
        in_suffix   = 1'b1;
      end else begin
        prefix_sym = (cfg_mode == MODE_SUBEXP);
        if (b == prefix_sym) begin
          prefix_len = prefix_len + 6'd1;
          if (prefix_len > 31) finish_word('0, 1'b1);
          return;
        end
        if (cfg_mode == MODE_SUBEXP) begin
          if (prefix_len == 0) enter_suffix('0, 6'(cfg_k));
          else enter_suffix(OUT_W'(1), 6'(prefix_len + cfg_k - 1));
        end else begin
          enter_suffix(OUT_W'(1), prefix_len);
        end
        return;
      end
    end
    acc = {acc[OUT_W-2:0], b};
    if (suffix_left <= 1) finish_word(acc, 1'b0);
    else suffix_left = suffix_left - 6'd1;
  endfunction

  function automatic void apply_write(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_DECODE_MODE: begin
        cfg_mode = mode_e'(data[1:0]);
        restart_decoder();
      end
      REG_VALUE_OFFSET: cfg_offset = data;
      REG_BETA_WIDTH:   cfg_beta   = data[5:0];
      REG_SUBEXP_K:     cfg_k      = data[4:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // The word sink stalls at random. Ready is redrawn on every edge.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Sends one code bit. Valid is left high after the handshake so that a
  // following bit goes out back to back; whoever comes next lowers it.
  task automatic send_bit(input logic b);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid    <= 1'b0;
      in_if.code_bit <= 1'($urandom);
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.code_bit <= b;
    do @(posedge clk); while (!in_if.ready);
    decode_bit(b);
    if (cfg_mode != MODE_HOLD) bits_decoded++;
  endtask

  // Sends the low n bits of value, most significant first.
  task automatic send_bits(input logic [63:0] value, input int n);
    for (int j = n - 1; j >= 0; j--) send_bit(value[j]);
  endtask

  // Waits until every owed word has come out and the pipeline has drained.
  task automatic settle_idle();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    settle_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk); while (!cfg_if.ready);
    apply_write(idx, data);
    cfg_if.valid <= 1'b0;
    writes_done++;
  endtask

  task automatic set_idling(input int unsigned phase_sel);
    case (phase_sel)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 52; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 52; end
      default: begin idle_pct = 14; stall_pct = 14; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Code word generators
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Prefix lengths lean short so that most words stay cheap; the long tail
  // still reaches 31, where suffixes grow past the word width.
  function automatic int unsigned pick_prefix();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(3);
    if (roll < 90) return $urandom_range(12, 4);
    return $urandom_range(31, 13);
  endfunction

  task automatic send_code_word();
    int unsigned len;
    len = pick_prefix();
    case (cfg_mode)
      MODE_BETA: begin
        send_bits(rand64(), (cfg_beta == 0) ? 1 : ((cfg_beta > 32) ? 32 : int'(cfg_beta)));
      end
      MODE_SUBEXP: begin
        if (len == 0) begin
          send_bit(1'b0);
          send_bits(rand64(), cfg_k);
        end else begin
          send_bits('1, len);
          send_bit(1'b0);
          send_bits(rand64(), len + cfg_k - 1);
        end
      end
      MODE_GAMMA: begin
        send_bits('0, len);
        send_bit(1'b1);
        send_bits(rand64(), len);
      end
      default: send_bits(rand64(), 8);
    endcase
  endtask

  // Thirty-two prefix symbols in a row overflow the prefix counter.
  task automatic send_long_prefix();
    send_bits((cfg_mode == MODE_SUBEXP) ? '1 : '0, 32);
  endtask

  // ---------------------------------------------------------------------------
  // Word checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, decoded_value %0d prefix_error %0b", $time,
                 out_if.decoded_value, out_if.prefix_error);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (want.prefix_error) errors_checked++;
        if (out_if.decoded_value !== want.decoded_value) begin
          $display("%0t: decoded_value mismatch, expected %0d, actual %0d", $time,
                   want.decoded_value, out_if.decoded_value);
          mismatches++;
        end
        if (out_if.prefix_error !== want.prefix_error) begin
          $display("%0t: prefix_error mismatch, expected %0b, actual %0b", $time,
                   want.prefix_error, out_if.prefix_error);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the block is in beta mode with eight-bit values.
  task automatic test_reset_defaults();
    send_bits(64'hA5, 8);
  endtask

  // A width of zero behaves as one; a one-bit width turns each bit into a
  // word, here with the offset at -1 so that every word wraps upward.
  task automatic test_beta_width_limits();
    cfg_write(REG_BETA_WIDTH, {$urandom} & ~32'h3F);
    send_bits(64'b10, 2);
    cfg_write(REG_VALUE_OFFSET, 32'hFFFF_FFFF);
    cfg_write(REG_BETA_WIDTH, 32'd1);
    send_bits(64'b10, 2);
  endtask

  // Subexponential words with k of zero and of two, including the shortest
  // words that finish on their terminating zero.
  task automatic test_subexp_codes();
    cfg_write(REG_VALUE_OFFSET, 32'h8000_0000);
    cfg_write(REG_SUBEXP_K, 32'd0);
    cfg_write(REG_DECODE_MODE, 32'(MODE_SUBEXP));
    send_bits(64'b0, 1);
    send_bits(64'b10, 2);
    send_bits(64'b1101, 4);
    cfg_write(REG_SUBEXP_K, 32'd2);
    send_bits(64'b010, 3);
    send_bits(64'b10_11, 4);
  endtask

  // Elias gamma words, with the offset at its largest positive value.
  task automatic test_gamma_codes();
    cfg_write(REG_VALUE_OFFSET, 32'h7FFF_FFFF);
    cfg_write(REG_DECODE_MODE, 32'(MODE_GAMMA));
    send_bits(64'b1, 1);
    send_bits(64'b011, 3);
  endtask

  // A 32-long gamma prefix gives an error word; the next bit starts afresh.
  task automatic test_prefix_overflow();
    send_long_prefix();
    send_bits(64'b1, 1);
  endtask

  // In hold mode bits are swallowed and nothing comes out, and leaving hold
  // mode restarts the decoder.
  task automatic test_hold_mode();
    cfg_write(REG_DECODE_MODE, 32'(MODE_HOLD));
    send_bits(64'b1010, 4);
    cfg_write(REG_VALUE_OFFSET, 32'd0);
    send_bits(64'b01, 2);
    cfg_write(REG_DECODE_MODE, 32'(MODE_GAMMA));
    send_bits(64'b1, 1);
  endtask

  // An offset write keeps a half-read word alive; a mode write discards it.
  task automatic test_mode_restart();
    send_bits(64'b00, 2);
    cfg_write(REG_VALUE_OFFSET, 32'd3);
    send_bits(64'b110, 3);
    send_bits(64'b000, 3);
    cfg_write(REG_DECODE_MODE, 32'(MODE_GAMMA));
    send_bits(64'b1, 1);
  endtask

  task automatic randomize_registers(input int unsigned round_no);
    logic [CFG_DATA_W-1:0] data;
    logic [1:0]            mode_code;
    case ($urandom_range(5))
      0: data = 32'h0000_0000;
      1: data = 32'h8000_0000;
      2: data = 32'h7FFF_FFFF;
      3: data = 32'hFFFF_FFFF;
      default: data = $urandom;
    endcase
    cfg_write(REG_VALUE_OFFSET, data);

    data = $urandom;
    case ($urandom_range(9))
      6: data[5:0] = 6'($urandom_range(32, 13));
      7: data[5:0] = 6'd32;
      8: data[5:0] = 6'($urandom_range(1));
      9: data[5:0] = 6'($urandom_range(63, 33));
      default: data[5:0] = 6'($urandom_range(12, 1));
    endcase
    cfg_write(REG_BETA_WIDTH, data);

    data = $urandom;
    case ($urandom_range(9))
      7, 8: data[4:0] = 5'($urandom_range(10, 4));
      9: data[4:0] = 5'($urandom_range(31, 11));
      default: data[4:0] = 5'($urandom_range(3));
    endcase
    cfg_write(REG_SUBEXP_K, data);

    // Now and then the mode is left alone so that a partial word carries
    // across the writes above.
    if (round_no == 0 || $urandom_range(3) != 0) begin
      mode_code = ($urandom_range(11) == 0) ? 2'(MODE_HOLD) : 2'($urandom_range(2));
      data      = {$urandom} & ~32'h3 | 32'(mode_code);
      cfg_write(REG_DECODE_MODE, data);
    end
  endtask

  // Rounds of random settings and idling. A hold-mode round is loose bits only;
  // otherwise most of each round is well-formed code words with random content
  // and the rest is loose bits and, outside beta mode, overflowing prefixes.
  task automatic test_random_streams();
    int unsigned round_no;
    int unsigned bit_goal;
    int unsigned word_goal;
    int unsigned round_end;
    int unsigned roll;
    round_no  = 0;
    bit_goal  = bits_decoded + RANDOM_BITS;
    word_goal = words_predicted + RANDOM_WORDS;
    while (bits_decoded < bit_goal || words_predicted < word_goal) begin
      set_idling(round_no % 4);
      randomize_registers(round_no);
      if (cfg_mode == MODE_HOLD) begin
        send_bits(rand64(), 24);
      end else begin
        round_end = bits_decoded + 50;
        while (bits_decoded < round_end) begin
          roll = $urandom_range(99);
          if (roll < 80) send_code_word();
          else if (roll < 93 || cfg_mode == MODE_BETA) send_bits(rand64(), $urandom_range(8, 1));
          else send_long_prefix();
        end
      end
      round_no++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_if.valid    = 1'b0;
    in_if.code_bit = 1'b0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = REG_DECODE_MODE;
    cfg_if.wdata   = '0;
    rst_n          = 1'b0;
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_beta_width_limits();
    test_subexp_codes();
    test_gamma_codes();
    test_prefix_overflow();
    test_hold_mode();
    test_mode_restart();
    test_random_streams();

    set_idling(0);
    settle_idle();
    $display("Decoded %0d code bits into %0d checked words (%0d prefix overflows).",
             bits_decoded, words_checked, errors_checked);
    $display("Applied %0d register writes across all modes and idling patterns.",
             writes_done);
    if (mismatches == 0) begin
      $display("integer_code_bit_decoder_top test passed");
    end else begin
      $display("integer_code_bit_decoder_top test failed");
    end
    $finish;
  end

  // Watchdog: a run that hangs on a handshake ends here.
  initial begin
    for (cycle_count = 0; cycle_count < MAX_CYCLES; cycle_count++) @(posedge clk);
    $display("%0t: timeout after %0d cycles, %0d words still owed", $time,
             MAX_CYCLES, expected_words.size());
    $display("integer_code_bit_decoder_top test failed");
    $finish;
  end

endmodule
